>>> sv/olp_pkg.sv
`default_nettype none

package olp_pkg;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam int NUM_PFX = 10;

    // Prefixes indexed by quantity code, left aligned and padded with spaces.
    localparam logic [111:0] PFX_TEXT [NUM_PFX] = '{
        "1-0:1.8.0*255 ",
        "1-0:2.8.0*255 ",
        "1-0:16.7.0*255",
        "1-0:36.7.0*255",
        "1-0:56.7.0*255",
        "1-0:76.7.0*255",
        "1-0:32.7.0*255",
        "1-0:52.7.0*255",
        "1-0:72.7.0*255",
        "0-0:96.8.0*255"
    };
    localparam logic [3:0] PFX_LEN [NUM_PFX] = '{
        4'd13, 4'd13, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14
    };

    localparam logic [3:0] Q_SECONDS = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EVAL,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        FMT_NONE,
        FMT_ENERGY,
        FMT_POWER,
        FMT_VOLT,
        FMT_SEC
    } fmt_t;

    typedef enum logic [2:0] {
        HX_WS,
        HX_SIGN,
        HX_ZERO,
        HX_X,
        HX_RUN,
        HX_DONE
    } hex_state_t;

    typedef enum logic {
        PK_DIG,
        PK_LIT
    } pat_kind_t;

    typedef struct packed {
        pat_kind_t  kind;
        logic [7:0] ch;
        logic       last;
    } pat_t;

    typedef struct packed {
        logic take;
        logic scan_start;
        logic scan_step;
        logic line_done;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_nl;
        logic line_ready;
        logic scan_last;
        logic result_ok;
    } status_t;

    function automatic logic [7:0] pfx_char(input logic [3:0] k, input logic [3:0] j);
        logic [111:0] txt;
        txt = PFX_TEXT[k];
        return txt[8 * (13 - j) +: 8];
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F)
            || (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_ZERO && c <= CH_NINE)
            v = c - CH_ZERO;
        else if (c >= CH_LO_A && c <= CH_LO_F)
            v = c - CH_LO_A + 8'd10;
        else
            v = c - CH_UP_A + 8'd10;
        return v[3:0];
    endfunction

    // Expected element at a given offset of each fixed-format number.
    function automatic pat_t fix_pat(input fmt_t fmt, input logic [4:0] off);
        pat_t p;
        p = '{kind: PK_LIT, ch: 8'h00, last: 1'b0};
        unique case (fmt)
            FMT_ENERGY:
            begin
                if (off <= 5'd5 || (off >= 5'd7 && off <= 5'd14))
                    p.kind = PK_DIG;
                else if (off == 5'd6)
                    p.ch = CH_DOT;
                else if (off == 5'd15)
                    p.ch = CH_STAR;
                else if (off == 5'd16)
                    p.ch = "k";
                else if (off == 5'd17)
                    p.ch = "W";
                else
                begin
                    p.ch = "h";
                    p.last = 1'b1;
                end
            end
            FMT_POWER:
            begin
                if (off <= 5'd5 || off == 5'd7 || off == 5'd8)
                    p.kind = PK_DIG;
                else if (off == 5'd6)
                    p.ch = CH_DOT;
                else if (off == 5'd9)
                    p.ch = CH_STAR;
                else
                begin
                    p.ch = "W";
                    p.last = 1'b1;
                end
            end
            FMT_VOLT:
            begin
                if (off <= 5'd2 || off == 5'd4)
                    p.kind = PK_DIG;
                else if (off == 5'd3)
                    p.ch = CH_DOT;
                else if (off == 5'd5)
                    p.ch = CH_STAR;
                else
                begin
                    p.ch = "V";
                    p.last = 1'b1;
                end
            end
            default:
            begin
                p.ch = 8'h00;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> sv/olp_ctrl.sv
`default_nettype none

module olp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              m_tready,
    input  wire olp_pkg::status_t  status,
    output olp_pkg::cmd_t          cmd,
    output logic                   s_tready,
    output logic                   m_tvalid
);
    import olp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign take = s_tvalid && state_reg == ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && status.is_nl && status.line_ready)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = status.result_ok ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.take       = take;
                cmd.scan_start = take && status.is_nl && status.line_ready;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_EVAL:
            begin
                cmd.line_done = 1'b1;
                cmd.load_out  = status.result_ok;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.scan_last) |=> state_reg == ST_DRAIN)
        else $error("scan did not hand over to drain");
    a_out_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_EVAL && $past(status.result_ok))
        else $error("result shown without a good evaluation");
    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take |-> !m_tvalid))
        else $error("byte taken while a result waits");
`endif

endmodule

`default_nettype wire

>>> sv/olp_datapath.sv
`default_nettype none

module olp_datapath #(
    parameter int LINE_BYTES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        rx_byte,
    input  wire olp_pkg::cmd_t     cmd,
    output olp_pkg::status_t       status,
    output logic [3:0]             quantity,
    output logic signed [47:0]     reading
);
    import olp_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);
    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(LINE_BYTES - 1);
    localparam logic [LW-1:0] LAST_FILL = LW'(LINE_BYTES - 1);
    localparam logic [AW-1:0] POS_E     = AW'(14);
    localparam logic [AW-1:0] POS_N     = AW'(15);
    localparam logic [LW-1:0] SEC_LEN   = LW'(24);

    logic [7:0] line_mem [LINE_BYTES];

    logic [LW-1:0] fill_reg;
    logic          skip_reg;
    logic [AW-1:0] scan_addr_reg;
    logic [7:0]    rdata_reg;
    logic [AW-1:0] pos_reg;
    logic          rdv_reg;

    // Parser state.
    logic               zero_reg,     zero_next;
    logic [LW-1:0]      len_reg,      len_next;
    logic               first_bad_reg, first_bad_next;
    logic [7:0]         last_reg,     last_next;
    logic [NUM_PFX-1:0] match_reg,    match_next;
    logic               fix_ok_reg,   fix_ok_next;
    logic               fix_done_reg, fix_done_next;
    logic [4:0]         off_reg,      off_next;
    logic               neg_reg,      neg_next;
    logic [47:0]        acc_reg,      acc_next;
    hex_state_t         hex_reg,      hex_next;

    logic [7:0]    c;
    logic [AW-1:0] start_pos;
    logic [3:0]    qty;
    fmt_t          fmt;
    pat_t          pat;
    logic          is_dig;
    logic [3:0]    dig;
    logic          is_ws;
    logic          result_ok;

    assign status.is_nl      = rx_byte == CH_LF;
    assign status.line_ready = !skip_reg && fill_reg != '0;
    assign status.scan_last  = scan_addr_reg == LAST_ADDR;
    assign status.result_ok  = result_ok;

    // Line store fill and overflow skip.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            skip_reg <= 1'b1;
        end
        else if (cmd.line_done)
        begin
            fill_reg <= '0;
            skip_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (rx_byte == CH_LF)
            begin
                if (!status.line_ready)
                begin
                    fill_reg <= '0;
                    skip_reg <= 1'b0;
                end
            end
            else if (rx_byte != CH_CR && !skip_reg)
            begin
                if (fill_reg == LAST_FILL)
                begin
                    fill_reg <= '0;
                    skip_reg <= 1'b1;
                end
                else
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && rx_byte != CH_LF && rx_byte != CH_CR && !skip_reg)
            line_mem[fill_reg[AW-1:0]] <= rx_byte;
        if (cmd.scan_step)
        begin
            rdata_reg <= line_mem[scan_addr_reg];
            pos_reg   <= scan_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            rdv_reg       <= 1'b0;
        end
        else
        begin
            rdv_reg <= cmd.scan_step;
            if (cmd.scan_start)
                scan_addr_reg <= '0;
            else if (cmd.scan_step)
                scan_addr_reg <= scan_addr_reg + 1'b1;
        end
    end

    // Effective character: zero past the fill and after the first zero byte.
    assign c = (rdv_reg && {1'b0, pos_reg} < {1'b0, fill_reg} && !zero_reg) ? rdata_reg : 8'h00;

    always_comb
    begin
        qty = '0;
        fmt = FMT_NONE;
        for (int k = NUM_PFX - 1; k >= 0; k--)
        begin
            if (match_reg[k])
                qty = 4'(k);
        end
        if (match_reg == '0)
            fmt = FMT_NONE;
        else if (qty <= 4'd1)
            fmt = FMT_ENERGY;
        else if (qty <= 4'd5)
            fmt = FMT_POWER;
        else if (qty <= 4'd8)
            fmt = FMT_VOLT;
        else
            fmt = FMT_SEC;
    end

    assign start_pos = (fmt == FMT_ENERGY) ? POS_E : POS_N;
    assign pat       = fix_pat(fmt, off_reg);
    assign is_dig    = c >= CH_ZERO && c <= CH_NINE;
    assign dig       = hex_val(c);
    assign is_ws     = c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;

    always_comb
    begin
        zero_next      = zero_reg;
        len_next       = len_reg;
        first_bad_next = first_bad_reg;
        last_next      = last_reg;
        match_next     = match_reg;
        fix_ok_next    = fix_ok_reg;
        fix_done_next  = fix_done_reg;
        off_next       = off_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        hex_next       = hex_reg;
        if (cmd.scan_start)
        begin
            zero_next      = 1'b0;
            len_next       = '0;
            first_bad_next = 1'b0;
            last_next      = '0;
            match_next     = '1;
            fix_ok_next    = 1'b1;
            fix_done_next  = 1'b0;
            off_next       = '0;
            neg_next       = 1'b0;
            acc_next       = '0;
            hex_next       = HX_WS;
        end
        else if (rdv_reg)
        begin
            if (c == 8'h00)
                zero_next = 1'b1;
            else
            begin
                len_next  = len_reg + 1'b1;
                last_next = c;
            end
            if (pos_reg == '0 && (c == CH_SLASH || c == CH_BANG))
                first_bad_next = 1'b1;
            for (int k = 0; k < NUM_PFX; k++)
            begin
                if ({1'b0, pos_reg} < (AW + 1)'(PFX_LEN[k]) && c != pfx_char(4'(k), pos_reg[3:0]))
                    match_next[k] = 1'b0;
            end
            if (pos_reg >= start_pos && (fmt == FMT_ENERGY || fmt == FMT_POWER
                || fmt == FMT_VOLT) && !fix_done_reg)
            begin
                if (fmt == FMT_POWER && pos_reg == POS_N && c == CH_MINUS)
                    neg_next = 1'b1;
                else
                begin
                    if (pat.kind == PK_DIG)
                    begin
                        if (is_dig)
                            acc_next = (acc_reg << 3) + (acc_reg << 1) + 48'(dig);
                        else
                            fix_ok_next = 1'b0;
                    end
                    else if (c != pat.ch)
                        fix_ok_next = 1'b0;
                    fix_done_next = pat.last;
                    off_next      = off_reg + 1'b1;
                end
            end
            if (fmt == FMT_SEC && pos_reg >= POS_N)
            begin
                case (hex_reg)
                    HX_WS, HX_SIGN:
                    begin
                        if (hex_reg == HX_WS && is_ws)
                            hex_next = HX_WS;
                        else if (hex_reg == HX_WS && (c == CH_PLUS || c == CH_MINUS))
                        begin
                            neg_next = c == CH_MINUS;
                            hex_next = HX_SIGN;
                        end
                        else if (is_hex(c))
                        begin
                            acc_next = 48'(dig);
                            hex_next = (c == CH_ZERO) ? HX_ZERO : HX_RUN;
                        end
                        else
                            hex_next = HX_DONE;
                    end
                    HX_ZERO:
                    begin
                        if (c == CH_LO_X || c == CH_UP_X)
                            hex_next = HX_X;
                        else if (is_hex(c))
                        begin
                            acc_next = (acc_reg << 4) + 48'(dig);
                            hex_next = HX_RUN;
                        end
                        else
                            hex_next = HX_DONE;
                    end
                    HX_X:
                    begin
                        if (is_hex(c))
                        begin
                            acc_next = 48'(dig);
                            hex_next = HX_RUN;
                        end
                        else
                            hex_next = HX_DONE;
                    end
                    HX_RUN:
                    begin
                        if (is_hex(c))
                            acc_next = (acc_reg << 4) + 48'(dig);
                        else
                            hex_next = HX_DONE;
                    end
                    default:
                    begin
                        hex_next = HX_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg      <= 1'b0;
            len_reg       <= '0;
            first_bad_reg <= 1'b0;
            last_reg      <= '0;
            match_reg     <= '0;
            fix_ok_reg    <= 1'b0;
            fix_done_reg  <= 1'b0;
            off_reg       <= '0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            hex_reg       <= HX_WS;
        end
        else
        begin
            zero_reg      <= zero_next;
            len_reg       <= len_next;
            first_bad_reg <= first_bad_next;
            last_reg      <= last_next;
            match_reg     <= match_next;
            fix_ok_reg    <= fix_ok_next;
            fix_done_reg  <= fix_done_next;
            off_reg       <= off_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            hex_reg       <= hex_next;
        end
    end

    always_comb
    begin
        result_ok = 1'b0;
        if (len_reg != '0 && !first_bad_reg && last_reg == CH_RPAR)
        begin
            if (fmt == FMT_SEC)
                result_ok = len_reg == SEC_LEN;
            else if (fmt != FMT_NONE)
                result_ok = fix_ok_reg && fix_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            quantity <= qty;
            reading  <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        end
    end

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LAST_FILL)
        else $error("line fill count out of range");
    a_skip_empty: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> fill_reg == '0)
        else $error("bytes held while skipping a line");
    a_read_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        rdv_reg |-> $past(cmd.scan_step))
        else $error("read data without a scan step");
    a_secs_code: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && fmt == FMT_SEC) |-> qty == Q_SECONDS)
        else $error("seconds format without its code");
`endif

endmodule

`default_nettype wire

>>> sv/obis_meter_line_parser_core.sv
`default_nettype none

// Parses the text output of a smart meter (IEC 62056-21 style) one character
// per beat. Carriage returns are dropped; other characters fill a line store of
// LINE_BYTES bytes, and a line that fills it is discarded up to its newline.
// The first line after reset is always discarded. A newline closing a stored
// line starts a scan that reads the store once, one byte a cycle from the
// single memory port, so such a newline holds off the next beat until the
// scan and its evaluation are done; other bytes are taken while idle. A
// recognised OBIS line with a well-formed number and unit gives one output
// beat carrying the quantity code and the scaled reading, which stays offered
// until taken; no further input is accepted meanwhile.
module obis_meter_line_parser_core #(
    parameter int LINE_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // [3:0] quantity, [51:4] reading, [55:52] zero
);
    import olp_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic [3:0]         quantity;
    logic signed [47:0] reading;

    olp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    olp_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .quantity (quantity),
        .reading  (reading)
    );

    // The reading is held in two's complement above the quantity code.
    assign m_tdata = {4'b0000, reading, quantity};

endmodule

`default_nettype wire
